// File: src/mts_pkg.sv
// shared types and constants for the max tracking stack
// no dependencies; compiled first
package mts_pkg;

	localparam int DEPTH_DEF      = 128;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int COUNT_FIELD_W  = 8;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_PUSH_FULL = 2'd1,
		STATUS_POP_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// File: src/mts_req_if.sv
// request channel of the max tracking stack: valid/ready plus operation beat
// depends on mts_pkg
interface mts_req_if
	import mts_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [FIELD_W-1:0] value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

// File: src/mts_rsp_if.sv
// result channel of the max tracking stack: valid/ready plus result beat
// depends on mts_pkg
interface mts_rsp_if
	import mts_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] popped_value;
	logic signed [FIELD_W-1:0] top_value;
	logic signed [FIELD_W-1:0] max_value;
	logic [COUNT_FIELD_W-1:0]  count;
	logic                      is_empty;
	logic                      is_full;
	logic [1:0]                status;

	modport source (output valid, popped_value, top_value, max_value, count, is_empty,
		is_full, status, input ready);
	modport sink   (input valid, popped_value, top_value, max_value, count, is_empty,
		is_full, status, output ready);
endinterface

// File: src/mts_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no package dependencies
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: src/max_tracking_stack_core.sv
// max tracking stack top level: control, top/max registers, two storage rams
// depends on mts_pkg, mts_req_if, mts_rsp_if, mts_ram
//
// A LIFO stack of signed values that reports its maximum on every result beat.
// Each request beat (push or pop) gives exactly one result beat carrying the
// popped value, the new top, the current maximum, the fill count, empty/full
// flags and a status code (push refused when full, pop refused when empty;
// a refused operation leaves the stack untouched). In the idle state the
// request is taken while, for a pop, the rams are read under and at the top
// slot; the execute state then applies the update and loads the result
// register, and waits there while an earlier result is still not taken. A
// new request is taken only once the previous one has executed. The result
// register lets a new request be taken while the previous result still waits.
// Top and maximum values live in registers; the value ram holds the stack, and
// the side ram holds, for every slot whose push raised the maximum, the index
// and value of the maximum it replaced, so a pop restores both at once.
// Neither ram needs clearing after reset: only written entries are ever used.
module max_tracking_stack_core
	import mts_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SIDE_W = IDX_W + DATA_WIDTH;

	state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] max_pos_q, max_pos_d;
	logic signed [DATA_WIDTH-1:0] top_val_q, top_val_d;
	logic signed [DATA_WIDTH-1:0] max_val_q, max_val_d;

	// request latched for the execute cycle
	logic                         act_s1;
	logic signed [DATA_WIDTH-1:0] val_s1;

	logic req_fire;
	logic exec_go;

	// ram ports
	logic                  val_we, side_we;
	logic [IDX_W-1:0]      val_waddr, val_raddr, side_raddr;
	logic [DATA_WIDTH-1:0] val_rdata;
	logic [SIDE_W-1:0]     side_wdata, side_rdata;
	logic                  rd_en;

	logic [IDX_W-1:0]             side_idx;
	logic signed [DATA_WIDTH-1:0] side_val;
	logic [IDX_W-1:0]             slot;

	// result beat contents
	status_t                      status_d;
	logic signed [DATA_WIDTH-1:0] popped_d;
	logic                         full_d;

	// result register
	logic                      out_valid_q;
	logic signed [FIELD_W-1:0] popped_q, top_q, max_q;
	logic [COUNT_FIELD_W-1:0]  count_out_q;
	logic                      empty_q, full_q;
	status_t                   status_q;

	assign req_fire = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		req.ready = 1'b0;
		exec_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_EXEC: exec_go = !out_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				exec_go   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// low DATA_WIDTH bits of the input, zero padded when the store is wider
	always_ff @(posedge clk) begin
		if (req_fire) begin
			act_s1 <= req.action;
			val_s1 <= DATA_WIDTH'($unsigned(req.value));
		end
	end

	// reads for a pop: value under the top and the top slot's saved maximum
	assign rd_en      = req_fire && (req.action == ACT_POP);
	assign val_raddr  = IDX_W'(count_q - CNT_W'(2));
	assign side_raddr = IDX_W'(count_q - CNT_W'(1));
	assign side_idx   = side_rdata[SIDE_W-1 -: IDX_W];
	assign side_val   = side_rdata[DATA_WIDTH-1:0];
	assign slot       = IDX_W'(count_q);

	// execute: update stack state from latched request and ram data
	always_comb begin
		count_d    = count_q;
		max_pos_d  = max_pos_q;
		top_val_d  = top_val_q;
		max_val_d  = max_val_q;
		status_d   = STATUS_OK;
		popped_d   = '0;
		val_we     = 1'b0;
		side_we    = 1'b0;
		val_waddr  = slot;
		side_wdata = {max_pos_q, max_val_q};
		if (act_s1 == ACT_PUSH) begin
			if (count_q >= CNT_W'(DEPTH)) begin
				status_d = STATUS_PUSH_FULL;
			end else begin
				val_we    = 1'b1;
				top_val_d = val_s1;
				count_d   = count_q + CNT_W'(1);
				if (count_q == '0) begin
					max_pos_d = '0;
					max_val_d = val_s1;
				end else if (val_s1 > max_val_q) begin
					// save the old maximum beside the new top
					side_we   = 1'b1;
					max_pos_d = slot;
					max_val_d = val_s1;
				end
			end
		end else begin
			if (count_q == '0) begin
				status_d = STATUS_POP_EMPTY;
			end else begin
				popped_d  = top_val_q;
				count_d   = count_q - CNT_W'(1);
				top_val_d = $signed(val_rdata);
				if (count_q == CNT_W'(1)) begin
					max_pos_d = '0;
				end else if (IDX_W'(count_q - CNT_W'(1)) == max_pos_q) begin
					max_pos_d = side_idx;
					max_val_d = side_val;
				end
			end
		end
	end

	assign full_d = count_d >= CNT_W'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			max_pos_q <= '0;
		end else if (exec_go) begin
			count_q   <= count_d;
			max_pos_q <= max_pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			top_val_q <= top_val_d;
			max_val_q <= max_val_d;
		end
	end

	mts_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (exec_go && val_we),
		.waddr (val_waddr),
		.wdata (val_s1),
		.re    (rd_en),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	mts_ram #(
		.WIDTH (SIDE_W),
		.DEPTH (DEPTH)
	) u_side_ram (
		.clk   (clk),
		.we    (exec_go && side_we),
		.waddr (slot),
		.wdata (side_wdata),
		.re    (rd_en),
		.raddr (side_raddr),
		.rdata (side_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// empty stack shows zero top and max
	always_ff @(posedge clk) begin
		if (exec_go) begin
			popped_q    <= FIELD_W'(popped_d);
			top_q       <= (count_d == '0) ? '0 : FIELD_W'(top_val_d);
			max_q       <= (count_d == '0) ? '0 : FIELD_W'(max_val_d);
			count_out_q <= COUNT_FIELD_W'(count_d);
			empty_q     <= (count_d == '0);
			full_q      <= full_d;
			status_q    <= status_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.top_value    = top_q;
	assign rsp.max_value    = max_q;
	assign rsp.count        = count_out_q;
	assign rsp.is_empty     = empty_q;
	assign rsp.is_full      = full_q;
	assign rsp.status       = status_q;

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack count exceeds depth");

	// the maximum points inside the filled part whenever the stack is not empty
	a_max_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CNT_W'(max_pos_q) < count_q))
		else $error("max position outside stack");

	// an empty stack keeps the maximum at slot zero
	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (max_pos_q == '0))
		else $error("empty stack with nonzero max position");

	// a taken request moves the fsm to the execute state in the following cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	// refused operations leave the count alone
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && (status_d != STATUS_OK)) |=> (count_q == $past(count_q)))
		else $error("refused operation changed the count");
endmodule

// File: verif/max_tracking_stack_core_test.sv
// self-checking testbench for max_tracking_stack_core: directed table, then random op phases
// depends on mts_pkg, mts_req_if, mts_rsp_if and the core itself
// every beat is checked against its typed table row or a stack predictor in this file
module max_tracking_stack_core_test;
	import mts_pkg::*;

	localparam int STACK_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_OPS   = 1200;
	localparam int STALL_MAX    = 12;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh80000000;

	// what one result beat carries
	typedef struct packed {
		logic signed [FIELD_W-1:0] popped;
		logic signed [FIELD_W-1:0] top;
		logic signed [FIELD_W-1:0] peak;
		logic [COUNT_FIELD_W-1:0]  count;
		logic                      empty;
		logic                      full;
		status_t                   status;
	} stack_beat_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		action_t                   act;
		logic signed [FIELD_W-1:0] val;
		logic                      typed;
		stack_beat_t               want;
	} op_row_t;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED,
		PH_NOISE
	} phase_t;

	logic clk;
	logic arst_n;

	mts_req_if req ();
	mts_rsp_if rsp ();

	max_tracking_stack_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// stack shadow: stored values, saved index of the previous peak, fill and peak index
	logic signed [FIELD_W-1:0] shadow_vals [STACK_DEPTH];
	int                        prior_peak  [STACK_DEPTH];
	int                        fill;
	int                        peak_at;

	stack_beat_t expected_beats [$];
	op_row_t     directed_ops   [$];
	int          errors;
	int          idle_cycles;
	bit          calm;

	always #1 clk = ~clk;

	// apply one op to the shadow stack and return the beat it should give
	function automatic stack_beat_t apply_op(action_t act, logic signed [FIELD_W-1:0] val);
		stack_beat_t r;
		r = '0;
		r.status = STATUS_OK;
		if (act == ACT_PUSH) begin
			if (fill >= STACK_DEPTH) begin
				r.status = STATUS_PUSH_FULL;
			end else if (fill == 0) begin
				shadow_vals[0] = val;
				peak_at = 0;
				fill = 1;
			end else begin
				shadow_vals[fill] = val;
				// equal values leave the old peak in place
				if (val > shadow_vals[peak_at]) begin
					prior_peak[fill] = peak_at;
					peak_at = fill;
				end
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.status = STATUS_POP_EMPTY;
			end else begin
				r.popped = shadow_vals[fill - 1];
				if (fill == 1)
					peak_at = 0;
				else if (fill - 1 == peak_at)
					peak_at = prior_peak[fill - 1];
				fill--;
			end
		end
		if (fill != 0) begin
			r.top  = shadow_vals[fill - 1];
			r.peak = shadow_vals[peak_at];
		end
		r.count = fill[COUNT_FIELD_W-1:0];
		r.empty = (fill == 0);
		r.full  = (fill >= STACK_DEPTH);
		return r;
	endfunction

	// full width random values, many small ones so that ties happen, and the extremes
	function automatic logic signed [FIELD_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return $urandom;
		if (sel < 17)
			return $urandom_range(0, 8) - 4;
		if (sel == 17)
			return VAL_MAX;
		if (sel == 18)
			return VAL_MIN;
		return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
	endfunction

	task automatic put_row(input action_t act, input logic signed [FIELD_W-1:0] val,
		input logic typed, input logic signed [FIELD_W-1:0] popped,
		input logic signed [FIELD_W-1:0] top, input logic signed [FIELD_W-1:0] peak,
		input int count, input logic empty, input logic full, input status_t status);
		op_row_t row;
		row.act         = act;
		row.val         = val;
		row.typed       = typed;
		row.want.popped = popped;
		row.want.top    = top;
		row.want.peak   = peak;
		row.want.count  = count[COUNT_FIELD_W-1:0];
		row.want.empty  = empty;
		row.want.full   = full;
		row.want.status = status;
		directed_ops.push_back(row);
	endtask

	// drive one request beat, wait for it to be taken, then queue its expected result
	task automatic send_op(input action_t act, input logic signed [FIELD_W-1:0] val,
		input logic typed, input stack_beat_t want);
		int          gap;
		stack_beat_t predicted;
		gap = calm ? 0 : $urandom_range(0, STALL_MAX);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.value  <= val;
		do @(posedge clk); while (!req.ready);
		predicted = apply_op(act, val);
		expected_beats.push_back(typed ? want : predicted);
	endtask

	task automatic send_random(input action_t act);
		send_op(act, pick_value(), 1'b0, '0);
	endtask

	// stimulus
	initial begin : stimulus
		phase_t kind;
		int     phase_no;
		int     issued;
		int     len;
		int     push_pct;
		clk        = 1'b0;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.action = ACT_PUSH;
		req.value  = '0;
		fill       = 0;
		peak_at    = 0;
		errors     = 0;
		calm       = 1'b0;

		// directed table: typed rows are read straight off the stack behavior
		put_row(ACT_POP,  32'sd0, 1, 0, 0, 0, 0, 1, 0, STATUS_POP_EMPTY);  // pop on empty
		put_row(ACT_PUSH, 32'sd5, 1, 0, 5, 5, 1, 0, 0, STATUS_OK);         // push onto empty
		put_row(ACT_PUSH, 32'sd5, 1, 0, 5, 5, 2, 0, 0, STATUS_OK);         // tie keeps old peak
		put_row(ACT_PUSH, VAL_MAX, 1, 0, VAL_MAX, VAL_MAX, 3, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, VAL_MIN, 1, 0, VAL_MIN, VAL_MAX, 4, 0, 0, STATUS_OK);
		put_row(ACT_POP,  32'sd0, 1, VAL_MIN, VAL_MAX, VAL_MAX, 3, 0, 0, STATUS_OK);
		put_row(ACT_POP,  32'sd0, 1, VAL_MAX, 5, 5, 2, 0, 0, STATUS_OK);   // peak restored
		put_row(ACT_POP,  32'sd0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_POP,  -32'sd9, 1, 5, 0, 0, 0, 1, 0, STATUS_OK);        // last value out
		put_row(ACT_POP,  32'sd0, 1, 0, 0, 0, 0, 1, 0, STATUS_POP_EMPTY);
		put_row(ACT_PUSH, VAL_MIN, 1, 0, VAL_MIN, VAL_MIN, 1, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, -32'sd1, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, -32'sd2, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, 32'sd0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, 32'sd0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, 32'sd3, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_PUSH, 32'sd3, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		repeat (7)
			put_row(ACT_POP, VAL_MAX, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);
		put_row(ACT_POP,  32'sd0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_ops[i])
			send_op(directed_ops[i].act, directed_ops[i].val, directed_ops[i].typed,
				directed_ops[i].want);

		// random phases: the first two fill to full and drain to empty
		issued   = 0;
		phase_no = 0;
		while (issued < RANDOM_OPS) begin
			if (phase_no == 0)
				kind = PH_FILL;
			else if (phase_no == 1)
				kind = PH_DRAIN;
			else
				kind = phase_t'($urandom_range(0, 3));
			calm = ($urandom_range(0, 3) == 0);
			case (kind)
				PH_FILL: begin
					while (fill < STACK_DEPTH) begin
						send_random(ACT_PUSH);
						issued++;
					end
					// refused pushes on a full stack
					len = $urandom_range(1, 3);
					repeat (len) send_random(ACT_PUSH);
					issued += len;
				end
				PH_DRAIN: begin
					while (fill > 0) begin
						send_random(ACT_POP);
						issued++;
					end
					len = $urandom_range(1, 3);
					repeat (len) send_random(ACT_POP);
					issued += len;
				end
				PH_MIXED: begin
					len      = $urandom_range(20, 120);
					push_pct = $urandom_range(30, 70);
					repeat (len)
						send_random($urandom_range(0, 99) < push_pct ? ACT_PUSH : ACT_POP);
					issued += len;
				end
				default: begin
					len = $urandom_range(5, 20);
					repeat (len) send_random(action_t'($urandom_range(0, 1)));
					issued += len;
				end
			endcase
			phase_no++;
		end

		// let every result come home, then a little extra for stray beats
		@(negedge clk);
		req.valid <= 1'b0;
		calm = 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("max_tracking_stack_core test passed");
		end else begin
			$display("max_tracking_stack_core test failed");
		end
		$finish;
	end

	// result sink: random back-pressure per beat, none in calm phases
	initial begin : result_sink
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, STALL_MAX);
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		stack_beat_t exp_beat;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_beat = expected_beats.pop_front();
					if (rsp.popped_value !== exp_beat.popped) begin
						$error("popped_value: expected %0d, got %0d", exp_beat.popped,
							rsp.popped_value);
						errors++;
					end
					if (rsp.top_value !== exp_beat.top) begin
						$error("top_value: expected %0d, got %0d", exp_beat.top, rsp.top_value);
						errors++;
					end
					if (rsp.max_value !== exp_beat.peak) begin
						$error("max_value: expected %0d, got %0d", exp_beat.peak, rsp.max_value);
						errors++;
					end
					if (rsp.count !== exp_beat.count) begin
						$error("count: expected %0d, got %0d", exp_beat.count, rsp.count);
						errors++;
					end
					if (rsp.is_empty !== exp_beat.empty) begin
						$error("is_empty: expected %0d, got %0d", exp_beat.empty, rsp.is_empty);
						errors++;
					end
					if (rsp.is_full !== exp_beat.full) begin
						$error("is_full: expected %0d, got %0d", exp_beat.full, rsp.is_full);
						errors++;
					end
					if (rsp.status !== exp_beat.status) begin
						$error("status: expected %0d, got %0d", exp_beat.status, rsp.status);
						errors++;
					end
				end
			end
			// any beat on either side counts as progress
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("max_tracking_stack_core test failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

endmodule

// File: max_tracking_stack_core.f
src/mts_pkg.sv
src/mts_req_if.sv
src/mts_rsp_if.sv
src/mts_ram.sv
src/max_tracking_stack_core.sv
verif/max_tracking_stack_core_test.sv
